@@ src/gpioirq_pkg.sv @@
`default_nettype none

package gpioirq_pkg;

    localparam int NUM_LINES_DEF = 8;
    localparam int NUM_LINES_MAX = 16;
    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int ADDR_W        = 4;
    localparam int REGIME_W      = 8;
    localparam int MODE_W        = 2;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] word_t;
    typedef logic [MODE_W-1:0] mode_t;

    localparam func_t FN_READ  = 2'd0;
    localparam func_t FN_WRITE = 2'd1;
    localparam func_t FN_TICK  = 2'd2;

    localparam addr_t ADDR_DATA    = 4'd0;
    localparam addr_t ADDR_DIR     = 4'd4;
    localparam addr_t ADDR_ENABLE  = 4'd8;
    localparam addr_t ADDR_REQUEST = 4'd9;
    localparam addr_t ADDR_TRIGGER = 4'd10;
    localparam addr_t ADDR_REGIME  = 4'd14;

    localparam mode_t MODE_LEVEL_LOW  = 2'd0;
    localparam mode_t MODE_LEVEL_HIGH = 2'd1;
    localparam mode_t MODE_RISING     = 2'd2;
    localparam mode_t MODE_FALLING    = 2'd3;

endpackage

`default_nettype wire

@@ src/gpioirq_in_if.sv @@
`default_nettype none

interface gpioirq_in_if #(
    parameter int NUM_LINES = gpioirq_pkg::NUM_LINES_DEF
);
    import gpioirq_pkg::*;

    logic                 valid;
    logic                 ready;
    func_t                func;
    addr_t                reg_index;
    word_t                write_data;
    logic [NUM_LINES-1:0] pin_levels;

    modport source (
        output valid,
        output func,
        output reg_index,
        output write_data,
        output pin_levels,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  reg_index,
        input  write_data,
        input  pin_levels,
        output ready
    );

endinterface

`default_nettype wire

@@ src/gpioirq_out_if.sv @@
`default_nettype none

interface gpioirq_out_if #(
    parameter int NUM_LINES = gpioirq_pkg::NUM_LINES_DEF
);
    import gpioirq_pkg::*;

    logic                 valid;
    logic                 ready;
    word_t                read_data;
    logic [NUM_LINES-1:0] pin_drive;
    logic [NUM_LINES-1:0] pin_output_enable;
    logic [NUM_LINES-1:0] irq_lines;

    modport source (
        output valid,
        output read_data,
        output pin_drive,
        output pin_output_enable,
        output irq_lines,
        input  ready
    );

    modport sink (
        input  valid,
        input  read_data,
        input  pin_drive,
        input  pin_output_enable,
        input  irq_lines,
        output ready
    );

endinterface

`default_nettype wire

@@ src/gpioirq_detect.sv @@
`default_nettype none

module gpioirq_detect #(
    parameter int NUM_LINES = gpioirq_pkg::NUM_LINES_DEF
) (
    input  wire logic [NUM_LINES-1:0]   pins,
    input  wire logic [NUM_LINES-1:0]   prev_pins,
    input  wire logic [2*NUM_LINES-1:0] modes,
    output logic      [NUM_LINES-1:0]   events
);
    import gpioirq_pkg::*;

    always_comb
    begin
        for (int i = 0; i < NUM_LINES; i++)
        begin
            case (mode_t'(modes[MODE_W*i +: MODE_W]))
                MODE_LEVEL_LOW:  events[i] = !pins[i];
                MODE_LEVEL_HIGH: events[i] = pins[i];
                MODE_RISING:     events[i] = !prev_pins[i] && pins[i];
                default:         events[i] = prev_pins[i] && !pins[i];
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/gpioirq_regs.sv @@
`default_nettype none

module gpioirq_regs #(
    parameter int NUM_LINES = gpioirq_pkg::NUM_LINES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire gpioirq_pkg::func_t     func,
    input  wire gpioirq_pkg::addr_t     reg_index,
    input  wire gpioirq_pkg::word_t     write_data,
    input  wire logic [NUM_LINES-1:0]   pin_levels,
    output gpioirq_pkg::word_t          read_data,
    output logic      [NUM_LINES-1:0]   pin_drive,
    output logic      [NUM_LINES-1:0]   pin_output_enable,
    output logic      [NUM_LINES-1:0]   irq_lines
);
    import gpioirq_pkg::*;

    localparam int MODES_W = MODE_W * NUM_LINES;

    logic [NUM_LINES-1:0] latch_reg,  latch_next;
    logic [NUM_LINES-1:0] dir_reg,    dir_next;
    logic [NUM_LINES-1:0] enable_reg, enable_next;
    logic [NUM_LINES-1:0] request_reg, request_next;
    logic [MODES_W-1:0]   trigger_reg, trigger_next;
    logic [REGIME_W-1:0]  regime_reg, regime_next;
    logic [NUM_LINES-1:0] prev_reg,   prev_next;
    logic [NUM_LINES-1:0] events;

    gpioirq_detect #(
        .NUM_LINES (NUM_LINES)
    ) u_detect (
        .pins      (pin_levels),
        .prev_pins (prev_reg),
        .modes     (trigger_reg),
        .events    (events)
    );

    // register read, from the state before the item
    always_comb
    begin
        read_data = '0;
        if (func == FN_READ)
        begin
            unique case (reg_index)
                ADDR_DATA:    read_data = DATA_W'((latch_reg & dir_reg) | (prev_reg & ~dir_reg));
                ADDR_DIR:     read_data = DATA_W'(dir_reg);
                ADDR_ENABLE:  read_data = DATA_W'(enable_reg);
                ADDR_REQUEST: read_data = DATA_W'(request_reg);
                ADDR_TRIGGER: read_data = DATA_W'(trigger_reg);
                ADDR_REGIME:  read_data = DATA_W'(regime_reg);
                default:      read_data = '0;
            endcase
        end
    end

    always_comb
    begin
        latch_next   = latch_reg;
        dir_next     = dir_reg;
        enable_next  = enable_reg;
        request_next = request_reg;
        trigger_next = trigger_reg;
        regime_next  = regime_reg;
        prev_next    = prev_reg;
        if (func == FN_WRITE)
        begin
            unique case (reg_index)
                ADDR_DATA:    latch_next   = write_data[NUM_LINES-1:0];
                ADDR_DIR:     dir_next     = write_data[NUM_LINES-1:0];
                ADDR_ENABLE:  enable_next  = write_data[NUM_LINES-1:0];
                ADDR_REQUEST: request_next = request_reg & write_data[NUM_LINES-1:0];
                ADDR_TRIGGER: trigger_next = write_data[MODES_W-1:0];
                ADDR_REGIME:  regime_next  = write_data[REGIME_W-1:0];
                default:      ;
            endcase
        end
        else if (func == FN_TICK)
        begin
            request_next = request_reg | events;
            prev_next    = pin_levels;
        end
    end

    // pin state as it stands after the item
    assign pin_drive         = latch_next;
    assign pin_output_enable = dir_next;
    assign irq_lines         = request_next & enable_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            dir_reg     <= '0;
            enable_reg  <= '0;
            request_reg <= '0;
            trigger_reg <= '0;
            regime_reg  <= '0;
            prev_reg    <= '0;
        end
        else if (step)
        begin
            latch_reg   <= latch_next;
            dir_reg     <= dir_next;
            enable_reg  <= enable_next;
            request_reg <= request_next;
            trigger_reg <= trigger_next;
            regime_reg  <= regime_next;
            prev_reg    <= prev_next;
        end
    end

endmodule

`default_nettype wire

@@ src/gpio_port_with_interrupt_detect.sv @@
// GPIO port of NUM_LINES lines with per-line interrupt detection. Each item on cmd is a
// register read, a register write or a pin sample tick; each gives exactly one item on rsp
// carrying the read word (zero unless a read) and the pin drive, output enables and
// interrupt lines as they stand after the item. Items go through an input register and a
// result register with one level of logic between them, so one item is taken per clock
// while rsp is not stalled; a result is offered on rsp from the result register, which it
// enters when its item leaves the input register. The input register takes one more item
// while a result waits on rsp; cmd stalls only when both are full and rsp.ready is low.
`default_nettype none

module gpio_port_with_interrupt_detect #(
    parameter int NUM_LINES = gpioirq_pkg::NUM_LINES_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    gpioirq_in_if.sink    cmd,
    gpioirq_out_if.source rsp
);
    import gpioirq_pkg::*;

    logic                 in_valid_reg;
    func_t                func_reg;
    addr_t                addr_reg;
    word_t                wdata_reg;
    logic [NUM_LINES-1:0] pins_reg;

    logic                 out_valid_reg;
    word_t                rdata_reg;
    logic [NUM_LINES-1:0] drive_reg;
    logic [NUM_LINES-1:0] oe_reg;
    logic [NUM_LINES-1:0] irq_reg;

    word_t                rdata_next;
    logic [NUM_LINES-1:0] drive_next;
    logic [NUM_LINES-1:0] oe_next;
    logic [NUM_LINES-1:0] irq_next;

    logic advance;
    logic take;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    gpioirq_regs #(
        .NUM_LINES (NUM_LINES)
    ) u_regs (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .func              (func_reg),
        .reg_index         (addr_reg),
        .write_data        (wdata_reg),
        .pin_levels        (pins_reg),
        .read_data         (rdata_next),
        .pin_drive         (drive_next),
        .pin_output_enable (oe_next),
        .irq_lines         (irq_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg  <= cmd.func;
            addr_reg  <= cmd.reg_index;
            wdata_reg <= cmd.write_data;
            pins_reg  <= cmd.pin_levels;
        end
        if (advance)
        begin
            rdata_reg <= rdata_next;
            drive_reg <= drive_next;
            oe_reg    <= oe_next;
            irq_reg   <= irq_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = rdata_reg;
    assign rsp.pin_drive         = drive_reg;
    assign rsp.pin_output_enable = oe_reg;
    assign rsp.irq_lines         = irq_reg;

endmodule

`default_nettype wire
